### rtl/ctrdrbg_pkg.sv
// Shared types, constants and AES helper functions for the CTR-DRBG word generator.
// Used by the controller, the datapath and the AES round unit; depends on nothing.
`default_nettype none

package ctrdrbg_pkg;

  localparam int BUFFER_WORDS = 32;
  localparam int BUF_AW       = $clog2(BUFFER_WORDS);
  localparam int WL_W         = $clog2(BUFFER_WORDS + 1);
  localparam int FILL_BLOCKS  = (BUFFER_WORDS + 3) / 4;
  localparam int FB_W         = (FILL_BLOCKS > 1) ? $clog2(FILL_BLOCKS) : 1;
  localparam int AES_ROUNDS   = 10;

  localparam logic [31:0] RESEED_LIMIT_RESET = 32'h7FFF_FFF0;

  typedef enum logic [1:0] {
    CMD_INSTANTIATE = 2'd0,
    CMD_RESEED      = 2'd1,
    CMD_DRAW32      = 2'd2,
    CMD_DRAW64      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    UPD_SEED,
    UPD_REFILL_SEED,
    UPD_POST_FILL
  } upd_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_U0,
    S_U0W,
    S_U1,
    S_U1W,
    S_F,
    S_FW,
    S_TAKE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic clear_kc;
    logic enc_start;
    logic upd_store;
    logic upd_finish;
    logic upd_seed;
    logic fill_clr;
    logic fill_store;
    logic gen_one;
    logic gen_inc;
    logic wl_clear;
    logic wl_fill;
    logic take_hi;
    logic take_lo;
    logic out_clear;
    logic out_raw;
    logic raw_wide;
    logic set_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic aes_done;
    logic gen_ready;
    logic wl_zero;
    logic over_limit;
    logic fill_last;
  } dp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 of a block sits in bits 127:120.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    int           c, i, src;
    for (c = 0; c < 4; c++) begin
      for (i = 0; i < 4; i++) begin
        src = ((c + i) % 4) * 4 + i;
        t[c * 4 + i] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    if (!last) begin
      for (c = 0; c < 4; c++) begin
        a0  = t[c * 4];
        a1  = t[c * 4 + 1];
        a2  = t[c * 4 + 2];
        a3  = t[c * 4 + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[c * 4]     = a0 ^ all ^ xt(a0 ^ a1);
        t[c * 4 + 1] = a1 ^ all ^ xt(a1 ^ a2);
        t[c * 4 + 2] = a2 ^ all ^ xt(a2 ^ a3);
        t[c * 4 + 3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = t[i];
    end
    return r ^ rk;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] bswap128(input logic [127:0] x);
    logic [127:0] r;
    int           b;
    for (b = 0; b < 16; b++) begin
      r[8 * b +: 8] = x[127 - 8 * b -: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

`default_nettype wire

### rtl/ctrdrbg_aes.sv
// Iterative AES-128 encryption unit: one round per cycle, round keys expanded on the fly.
// Depends on ctrdrbg_pkg.
`default_nettype none

module ctrdrbg_aes
  import ctrdrbg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic [127:0] result,
  output logic         done
);

  logic [127:0] st;
  logic [127:0] rk;
  logic [127:0] rk_next;
  logic [7:0]   rcon;
  logic [3:0]   rnd;
  logic         busy;
  logic         last;

  assign rk_next = key_step(rk, rcon);
  assign last    = (rnd == 4'(AES_ROUNDS));
  assign result  = st;

  always_ff @(posedge clk) begin
    if (start) begin
      st   <= blk ^ key;
      rk   <= key;
      rcon <= 8'h01;
    end else if (busy) begin
      st   <= aes_round(st, rk_next, last);
      rk   <= rk_next;
      rcon <= xt(rcon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        rnd  <= 4'd1;
      end else if (busy) begin
        rnd <= rnd + 4'd1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ctrdrbg_dp.sv
// Datapath: key, counter, word buffer, counts, result register and the AES unit.
// Depends on ctrdrbg_pkg and ctrdrbg_aes; driven by commands from ctrdrbg_ctrl.
`default_nettype none

module ctrdrbg_dp
  import ctrdrbg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     c,
  output dp_status_t  status,
  input  logic [63:0] entropy_0,
  input  logic [63:0] entropy_1,
  input  logic [63:0] entropy_2,
  input  logic [63:0] entropy_3,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic [63:0] random_value,
  output logic        from_raw_entropy
);

  logic [127:0]      key;
  logic [127:0]      ctr;
  logic [127:0]      ctr_inc;
  logic [127:0]      mat0;
  logic [127:0]      seed_a;
  logic [127:0]      seed_b;
  logic [127:0]      aes_out;
  logic [63:0]       ent [4];
  logic [31:0]       wbuf [BUFFER_WORDS];
  logic [31:0]       rd_word;
  logic [BUF_AW-1:0] rd_ptr;
  logic [WL_W-1:0]   words_left;
  logic [31:0]       gen;
  logic [31:0]       limit;
  logic              ready;
  logic [FB_W-1:0]   fb;
  logic              aes_done;

  assign ctr_inc = ctr + 128'd1;
  assign seed_a  = bswap128({ent[1], ent[0]});
  assign seed_b  = bswap128({ent[3], ent[2]});
  assign rd_word = wbuf[rd_ptr];

  assign status.aes_done   = aes_done;
  assign status.gen_ready  = ready;
  assign status.wl_zero    = (words_left == '0);
  assign status.over_limit = (gen > limit);
  assign status.fill_last  = (fb == FB_W'(FILL_BLOCKS - 1));

  ctrdrbg_aes u_aes (
    .clk    (clk),
    .rst    (rst),
    .start  (c.enc_start),
    .key    (key),
    .blk    (ctr_inc),
    .result (aes_out),
    .done   (aes_done)
  );

  always_ff @(posedge clk) begin
    if (c.latch_in) begin
      ent[0] <= entropy_0;
      ent[1] <= entropy_1;
      ent[2] <= entropy_2;
      ent[3] <= entropy_3;
    end
    if (c.clear_kc) begin
      key <= '0;
      ctr <= '0;
    end else if (c.enc_start) begin
      ctr <= ctr_inc;
    end else if (c.upd_finish) begin
      key <= mat0 ^ (c.upd_seed ? seed_a : '0);
      ctr <= aes_out ^ (c.upd_seed ? seed_b : '0);
    end
    if (c.upd_store) begin
      mat0 <= aes_out;
    end
    // drop words of the last block that fall past the buffer
    if (c.fill_store) begin
      for (int j = 0; j < 4; j++) begin
        if (int'({fb, 2'(j)}) < BUFFER_WORDS) begin
          wbuf[BUF_AW'({fb, 2'(j)})] <= bswap32(aes_out[127 - 32 * j -: 32]);
        end
      end
    end
    if (c.out_raw) begin
      random_value     <= c.raw_wide ? entropy_0 : {32'd0, entropy_0[31:0]};
      from_raw_entropy <= 1'b1;
    end else if (c.out_clear) begin
      random_value     <= '0;
      from_raw_entropy <= 1'b0;
    end else if (c.take_hi) begin
      random_value[63:32] <= rd_word;
    end else if (c.take_lo) begin
      random_value[31:0] <= rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= RESEED_LIMIT_RESET;
      gen        <= '0;
      words_left <= '0;
      rd_ptr     <= '0;
      ready      <= 1'b0;
      fb         <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (c.gen_one) begin
        gen <= 32'd1;
      end else if (c.gen_inc) begin
        gen <= gen + 32'd1;
      end
      if (c.wl_clear) begin
        words_left <= '0;
      end else if (c.wl_fill) begin
        words_left <= WL_W'(BUFFER_WORDS);
        rd_ptr     <= '0;
      end else if (c.take_hi || c.take_lo) begin
        words_left <= words_left - WL_W'(1);
        rd_ptr     <= rd_ptr + BUF_AW'(1);
      end
      if (c.set_ready) begin
        ready <= 1'b1;
      end
      if (c.fill_clr) begin
        fb <= '0;
      end else if (c.fill_store) begin
        fb <= fb + FB_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ctrdrbg_ctrl.sv
// Controller state machine: sequences seeding, updates, buffer refills and draws.
// Depends on ctrdrbg_pkg; drives ctrdrbg_dp through a command struct.
`default_nettype none

module ctrdrbg_ctrl
  import ctrdrbg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    c
);

  state_t    state, state_next;
  upd_kind_t kind, kind_next;
  cmd_t      cmd_q, cmd_next;
  logic      half, half_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= UPD_SEED;
      cmd_q <= CMD_INSTANTIATE;
      half  <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      cmd_q <= cmd_next;
      half  <= half_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd_next   = cmd_q;
    half_next  = half;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next  = cmd_t'(cmd);
          half_next = 1'b0;
          kind_next = UPD_SEED;
          unique case (cmd_t'(cmd))
            CMD_INSTANTIATE: state_next = S_U0;
            CMD_RESEED:      state_next = status.gen_ready ? S_U0 : S_OUT;
            default:         state_next = status.gen_ready ? S_CHK : S_OUT;
          endcase
        end
      end
      S_CHK: begin
        if (!status.wl_zero) begin
          state_next = S_TAKE;
        end else if (status.over_limit) begin
          state_next = S_U0;
          kind_next  = UPD_REFILL_SEED;
        end else begin
          state_next = S_F;
        end
      end
      S_U0:  state_next = S_U0W;
      S_U0W: if (status.aes_done) state_next = S_U1;
      S_U1:  state_next = S_U1W;
      S_U1W: begin
        if (status.aes_done) begin
          unique case (kind)
            UPD_SEED:        state_next = S_OUT;
            UPD_REFILL_SEED: state_next = S_F;
            default:         state_next = S_TAKE;
          endcase
        end
      end
      S_F:  state_next = S_FW;
      S_FW: begin
        if (status.aes_done) begin
          if (status.fill_last) begin
            state_next = S_U0;
            kind_next  = UPD_POST_FILL;
          end else begin
            state_next = S_F;
          end
        end
      end
      S_TAKE: begin
        // high word first, then go back for the low word
        if (cmd_q == CMD_DRAW64 && !half) begin
          half_next  = 1'b1;
          state_next = S_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    c         = '0;
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          c.latch_in  = 1'b1;
          c.out_clear = 1'b1;
          c.clear_kc  = (cmd_t'(cmd) == CMD_INSTANTIATE);
          c.out_raw   = !status.gen_ready &&
                        (cmd_t'(cmd) == CMD_DRAW32 || cmd_t'(cmd) == CMD_DRAW64);
          c.raw_wide  = (cmd_t'(cmd) == CMD_DRAW64);
        end
      end
      S_CHK: c.fill_clr = status.wl_zero;
      S_U0, S_U1, S_F: c.enc_start = 1'b1;
      S_U0W: c.upd_store = status.aes_done;
      S_U1W: begin
        if (status.aes_done) begin
          c.upd_finish = 1'b1;
          c.upd_seed   = (kind != UPD_POST_FILL);
          unique case (kind)
            UPD_SEED: begin
              c.gen_one   = 1'b1;
              c.wl_clear  = 1'b1;
              c.set_ready = (cmd_q == CMD_INSTANTIATE);
            end
            UPD_REFILL_SEED: c.gen_one = 1'b1;
            default: begin
              c.gen_inc = 1'b1;
              c.wl_fill = 1'b1;
            end
          endcase
        end
      end
      S_FW: c.fill_store = status.aes_done;
      S_TAKE: begin
        c.take_hi = (cmd_q == CMD_DRAW64) && !half;
        c.take_lo = !((cmd_q == CMD_DRAW64) && !half);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/aes128_ctr_drbg_word_generator.sv
// Top level of the AES-128 CTR-DRBG word generator: controller plus datapath.
// Depends on ctrdrbg_pkg, ctrdrbg_ctrl and ctrdrbg_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | cmd, entropy_0..entropy_3
//  out      | out_valid / out_stall| random_value, from_raw_entropy
//  cfg      | cfg_valid / cfg_ready| reseed_limit
//
// One request at a time. Seeding runs two AES blocks through the iterative unit; a refill
// runs eight more blocks plus an update, and another update before them when it reseeds.
// Synchronous active-high reset; no clearing pass. The input stalls while a request is
// in work or its result waits on out_stall.
`default_nettype none

module aes128_ctr_drbg_word_generator
  import ctrdrbg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] entropy_0,
  input  logic [63:0] entropy_1,
  input  logic [63:0] entropy_2,
  input  logic [63:0] entropy_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_value,
  output logic        from_raw_entropy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] reseed_limit
);

  dp_cmd_t    dcmd;
  dp_status_t dstat;

  assign cfg_ready = 1'b1;

  ctrdrbg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dstat),
    .c         (dcmd)
  );

  ctrdrbg_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .c                (dcmd),
    .status           (dstat),
    .entropy_0        (entropy_0),
    .entropy_1        (entropy_1),
    .entropy_2        (entropy_2),
    .entropy_3        (entropy_3),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (reseed_limit),
    .random_value     (random_value),
    .from_raw_entropy (from_raw_entropy)
  );

endmodule

`default_nettype wire

### rtl/ctrdrbg_checker.sv
// Port-level checker for the CTR-DRBG word generator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ctrdrbg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] random_value
);

  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result waits");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was taken");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("stalled result changed");

endmodule

bind aes128_ctr_drbg_word_generator ctrdrbg_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_value (random_value)
);

`default_nettype wire

### tb/sv/drbg_checker.sv
// Checker for the CTR-DRBG word generator: watches the request, result and
// register channels, predicts each result and compares. Depends on ctrdrbg_pkg.
module drbg_checker
  import ctrdrbg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] entropy_0,
  input  logic [63:0] entropy_1,
  input  logic [63:0] entropy_2,
  input  logic [63:0] entropy_3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] random_value,
  input  logic        from_raw_entropy,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] reseed_limit,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [63:0] value;
    logic        raw;
  } draw_result_t;

  localparam logic [7:0] S [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Blocks are byte arrays, index 0 first, as in the standard.
  logic [7:0]  key [16];
  logic [7:0]  ctr [16];
  logic [31:0] words [BUFFER_WORDS];
  int          remaining;
  logic [31:0] gen_count;
  logic [31:0] limit;
  logic        seeded;
  draw_result_t expected_q [$];

  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void cipher(input logic [7:0] k [16], input logic [7:0] pt [16],
                                 output logic [7:0] ct [16]);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tt [16];
    logic [7:0] tw [4];
    logic [7:0] rc, f, a0, a1, a2, a3, x;
    int i, j, r, c;
    rc = 8'h01;
    for (i = 0; i < 16; i++) rk[i] = k[i];
    for (i = 16; i < 176; i += 4) begin
      for (j = 0; j < 4; j++) tw[j] = rk[i - 4 + j];
      if (i % 16 == 0) begin
        f = tw[0];
        tw[0] = S[tw[1]] ^ rc;
        tw[1] = S[tw[2]];
        tw[2] = S[tw[3]];
        tw[3] = S[f];
        rc = dbl(rc);
      end
      for (j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ tw[j];
    end
    for (i = 0; i < 16; i++) st[i] = pt[i] ^ rk[i];
    for (r = 1; r <= 10; r++) begin
      for (c = 0; c < 4; c++)
        for (i = 0; i < 4; i++) tt[c * 4 + i] = S[st[((c + i) % 4) * 4 + i]];
      if (r != 10) begin
        for (c = 0; c < 4; c++) begin
          a0 = tt[c * 4]; a1 = tt[c * 4 + 1]; a2 = tt[c * 4 + 2]; a3 = tt[c * 4 + 3];
          x = a0 ^ a1 ^ a2 ^ a3;
          tt[c * 4]     = a0 ^ x ^ dbl(a0 ^ a1);
          tt[c * 4 + 1] = a1 ^ x ^ dbl(a1 ^ a2);
          tt[c * 4 + 2] = a2 ^ x ^ dbl(a2 ^ a3);
          tt[c * 4 + 3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (i = 0; i < 16; i++) st[i] = tt[i] ^ rk[r * 16 + i];
    end
    for (i = 0; i < 16; i++) ct[i] = st[i];
  endfunction

  function automatic void bump();
    int i;
    for (i = 15; i >= 0; i--) begin
      ctr[i] = ctr[i] + 8'd1;
      if (ctr[i] != 8'd0) break;
    end
  endfunction

  function automatic void mix_in(input logic [7:0] data [32]);
    logic [7:0] b0 [16];
    logic [7:0] b1 [16];
    int i;
    bump();
    cipher(key, ctr, b0);
    bump();
    cipher(key, ctr, b1);
    for (i = 0; i < 16; i++) begin
      key[i] = b0[i] ^ data[i];
      ctr[i] = b1[i] ^ data[16 + i];
    end
  endfunction

  function automatic void refill(input logic [7:0] seed [32]);
    logic [7:0] blk [16];
    logic [7:0] zero [32];
    int b, j;
    if (gen_count > limit) begin
      mix_in(seed);
      gen_count = 1;
    end
    for (b = 0; b * 4 < BUFFER_WORDS; b++) begin
      bump();
      cipher(key, ctr, blk);
      for (j = 0; j < 4; j++)
        if (b * 4 + j < BUFFER_WORDS)
          words[b * 4 + j] = {blk[4 * j + 3], blk[4 * j + 2], blk[4 * j + 1], blk[4 * j]};
    end
    for (j = 0; j < 32; j++) zero[j] = 8'd0;
    mix_in(zero);
    gen_count = gen_count + 32'd1;
    remaining = BUFFER_WORDS;
  endfunction

  function automatic logic [31:0] take_word(input logic [7:0] seed [32]);
    int idx;
    logic [31:0] v;
    if (remaining == 0) refill(seed);
    idx = BUFFER_WORDS - remaining;
    v = words[idx];
    words[idx] = 32'd0;
    remaining--;
    return v;
  endfunction

  function automatic draw_result_t predict_draw(input cmd_t op, input logic [63:0] e [4]);
    logic [7:0] seed [32];
    draw_result_t res;
    logic [31:0] hi;
    int k, i;
    for (k = 0; k < 4; k++)
      for (i = 0; i < 8; i++) seed[k * 8 + i] = e[k][8 * i +: 8];
    res.value = 64'd0;
    res.raw = 1'b0;
    case (op)
      CMD_INSTANTIATE: begin
        for (i = 0; i < 16; i++) begin
          key[i] = 8'd0;
          ctr[i] = 8'd0;
        end
        mix_in(seed);
        gen_count = 1;
        remaining = 0;
        seeded = 1'b1;
      end
      CMD_RESEED: begin
        if (seeded) begin
          mix_in(seed);
          remaining = 0;
          gen_count = 1;
        end
      end
      CMD_DRAW32: begin
        if (!seeded) begin
          res.value = {32'd0, e[0][31:0]};
          res.raw = 1'b1;
        end else begin
          res.value = {32'd0, take_word(seed)};
        end
      end
      default: begin
        if (!seeded) begin
          res.value = e[0];
          res.raw = 1'b1;
        end else begin
          hi = take_word(seed);
          res.value = {hi, take_word(seed)};
        end
      end
    endcase
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    logic [63:0] e [4];
    draw_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < 16; i++) begin
        key[i] = 8'd0;
        ctr[i] = 8'd0;
      end
      for (i = 0; i < BUFFER_WORDS; i++) words[i] = 32'd0;
      remaining = 0;
      gen_count = 0;
      limit = RESEED_LIMIT_RESET;
      seeded = 1'b0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit = reseed_limit;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: random_value %h", random_value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (random_value !== want.value) begin
            $error("random_value expected %h actual %h", want.value, random_value);
            fail_count++;
          end
          if (from_raw_entropy !== want.raw) begin
            $error("from_raw_entropy expected %b actual %b", want.raw, from_raw_entropy);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        e[0] = entropy_0;
        e[1] = entropy_1;
        e[2] = entropy_2;
        e[3] = entropy_3;
        expected_q.push_back(predict_draw(cmd_t'(cmd), e));
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// Top of the CTR-DRBG word generator testbench: clock, reset, requests,
// register writes and verdict. Depends on ctrdrbg_pkg and drbg_checker.
module tb_top;
  import ctrdrbg_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [63:0] entropy_0, entropy_1, entropy_2, entropy_3;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] random_value;
  logic        from_raw_entropy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] reseed_limit;
  int          fail_count;
  int          pending;
  logic        hold_off;
  logic        sending_done;

  aes128_ctr_drbg_word_generator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .entropy_0(entropy_0), .entropy_1(entropy_1),
    .entropy_2(entropy_2), .entropy_3(entropy_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .random_value(random_value), .from_raw_entropy(from_raw_entropy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .reseed_limit(reseed_limit)
  );

  drbg_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .entropy_0(entropy_0), .entropy_1(entropy_1),
    .entropy_2(entropy_2), .entropy_3(entropy_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .random_value(random_value), .from_raw_entropy(from_raw_entropy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .reseed_limit(reseed_limit),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Offer one request and hold it until accepted; drop valid only during a gap.
  task automatic send_request(input cmd_t op, input logic [63:0] e0, input logic [63:0] e1,
                              input logic [63:0] e2, input logic [63:0] e3, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    entropy_0 <= e0;
    entropy_1 <= e1;
    entropy_2 <= e2;
    entropy_3 <= e3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input cmd_t op);
    send_request(op, edge_value(), edge_value(), edge_value(), edge_value(), 1'b1);
  endtask

  task automatic write_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_valid <= 1'b1;
    reseed_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int i, w;
    for (i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 2) send_random(CMD_INSTANTIATE);
      else if (w < 5) send_random(CMD_RESEED);
      else if (w < 55) send_random(CMD_DRAW32);
      else send_random(CMD_DRAW64);
    end
  endtask

  // Receiver: random stall per result, with one long hold-off.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_INSTANTIATE;
    entropy_0 = '0;
    entropy_1 = '0;
    entropy_2 = '0;
    entropy_3 = '0;
    cfg_valid = 1'b0;
    reseed_limit = '0;
    hold_off = 1'b0;
    sending_done = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Uninstantiated: reseed ignored, draws return raw entropy.
    send_request(CMD_RESEED, '1, '1, '1, '1, 1'b0);
    send_request(CMD_DRAW32, '1, 64'd0, '1, 64'd0, 1'b0);
    send_request(CMD_DRAW64, 64'hA5A5_5A5A_0123_4567, '1, 64'd0, '1, 1'b0);
    send_request(CMD_DRAW64, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    send_request(CMD_INSTANTIATE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    for (i = 0; i < 5; i++) send_random(CMD_DRAW32);
    send_request(CMD_INSTANTIATE, '1, '1, '1, '1, 1'b0);
    send_random(CMD_DRAW64);
    send_random(CMD_RESEED);
    send_random(CMD_DRAW32);
    // Walk into a 64-bit draw that straddles a refill.
    for (i = 0; i < 30; i++) send_random(CMD_DRAW32);
    send_random(CMD_DRAW64);

    // Limit of one: each refill after the first since seeding reseeds, also inside a 64-bit draw.
    write_limit(32'd1);
    send_random(CMD_INSTANTIATE);
    random_phase(300);

    // Fill up while the receiver holds off.
    hold_off = 1'b1;
    random_phase(20);

    write_limit(32'hFFFF_FFFF);
    random_phase(300);
    write_limit(32'd3);
    random_phase(300);
    write_limit(32'h0000_0000);
    random_phase(200);
    write_limit(RESEED_LIMIT_RESET);
    random_phase(80);
    in_valid <= 1'b0;
    sending_done = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
